[rtl/round_robin_quantum_scheduler_unit_defines.svh]
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler assertion macros
// Shared property forms for the scheduler's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on the rising clock outside reset.
`define RRQS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock outside reset.
`define RRQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rrqs_pkg.sv]
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler package
// Widths, command codes and the controller/datapath control structs.
// ----------------------------------------------------------------------------
package rrqs_pkg;

  localparam int SlotCountDefault = 8;
  localparam int SlotIdxW         = 3;
  localparam int TimeW            = 16;

  typedef enum logic {
    CmdLoad = 1'b0,
    CmdStep = 1'b1
  } cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_en;
    logic step_en;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cmd_step;
  } dp_sts_t;

endpackage

[rtl/rrqs_channels.sv]
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler channels
// Valid/ready channel interfaces for requests, results and configuration.
// ----------------------------------------------------------------------------
interface rrqs_req_if;
  import rrqs_pkg::*;

  logic                valid;
  logic                ready;
  logic                command;
  logic [SlotIdxW-1:0] slot_index;
  logic [TimeW-1:0]    burst_time;

  modport source (output valid, command, slot_index, burst_time, input ready);
  modport sink   (input valid, command, slot_index, burst_time, output ready);
endinterface

interface rrqs_rsp_if;
  import rrqs_pkg::*;

  logic                valid;
  logic                ready;
  logic [SlotIdxW-1:0] served_slot;
  logic [TimeW-1:0]    run_time;
  logic                job_finished;
  logic                all_idle;

  modport source (output valid, served_slot, run_time, job_finished, all_idle,
                  input ready);
  modport sink   (input valid, served_slot, run_time, job_finished, all_idle,
                  output ready);
endinterface

interface rrqs_cfg_if;
  import rrqs_pkg::*;

  logic             valid;
  logic             ready;
  logic [TimeW-1:0] time_quantum;

  modport source (output valid, time_quantum, input ready);
  modport sink   (input valid, time_quantum, output ready);
endinterface

[rtl/rrqs_datapath.sv]
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler datapath
// Slot times, turn pointer, quantum register, rotating pick and result register.
// ----------------------------------------------------------------------------
module rrqs_datapath #(
  parameter int SLOT_COUNT = rrqs_pkg::SlotCountDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rrqs_pkg::ctrl_cmd_t                cmd_i,
  output rrqs_pkg::dp_sts_t                  sts_o,
  input  logic                               req_command_i,
  input  logic [rrqs_pkg::SlotIdxW-1:0]      req_slot_index_i,
  input  logic [rrqs_pkg::TimeW-1:0]         req_burst_time_i,
  input  logic                               cfg_we_i,
  input  logic [rrqs_pkg::TimeW-1:0]         cfg_time_quantum_i,
  output logic [rrqs_pkg::TimeW-1:0]         quantum_o,
  output logic [rrqs_pkg::SlotIdxW-1:0]      served_slot_o,
  output logic [rrqs_pkg::TimeW-1:0]         run_time_o,
  output logic                               job_finished_o,
  output logic                               all_idle_o
);
  import rrqs_pkg::*;

  localparam int PtrW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [PtrW-1:0] LastSlot = PtrW'(SLOT_COUNT - 1);

  // Lowest set bit of a slot vector.
  function automatic logic [PtrW-1:0] first_set(input logic [SLOT_COUNT-1:0] vec);
    logic [PtrW-1:0] idx;
    idx = '0;
    for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
      if (vec[k]) begin
        idx = PtrW'(k);
      end
    end
    return idx;
  endfunction

  logic [TimeW-1:0]    remaining_q [SLOT_COUNT];
  logic [PtrW-1:0]     pointer_q;
  logic [TimeW-1:0]    quantum_q;
  logic                command_q;
  logic [SlotIdxW-1:0] slot_index_q;
  logic [TimeW-1:0]    burst_time_q;

  logic [SLOT_COUNT-1:0] busy;
  logic [SLOT_COUNT-1:0] upper;
  logic                  any_busy;
  logic [PtrW-1:0]       sel;
  logic [TimeW-1:0]      sel_rem;
  logic                  fin;
  logic [TimeW-1:0]      run;
  logic                  load_hit;

  // Rotating priority: first busy slot at or above the pointer, else the
  // first busy slot from the bottom.
  always_comb begin
    for (int k = 0; k < SLOT_COUNT; k++) begin
      busy[k]  = (remaining_q[k] != '0);
      upper[k] = busy[k] && (PtrW'(k) >= pointer_q);
    end
    any_busy = |busy;
    sel      = (|upper) ? first_set(upper) : first_set(busy);
    sel_rem  = remaining_q[sel];
    fin      = (sel_rem <= quantum_q);
    run      = fin ? sel_rem : quantum_q;
    load_hit = (int'(slot_index_q) < SLOT_COUNT);
  end

  assign sts_o.cmd_step = (command_q == CmdStep);
  assign quantum_o      = quantum_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      command_q    <= req_command_i;
      slot_index_q <= req_slot_index_i;
      burst_time_q <= req_burst_time_i;
    end
    if (cmd_i.step_en) begin
      served_slot_o  <= any_busy ? SlotIdxW'(sel) : '0;
      run_time_o     <= any_busy ? run : '0;
      job_finished_o <= any_busy && fin;
      all_idle_o     <= !any_busy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        remaining_q[k] <= '0;
      end
      pointer_q <= '0;
      quantum_q <= TimeW'(1);
    end else begin
      if (cfg_we_i) begin
        quantum_q <= (cfg_time_quantum_i == '0) ? TimeW'(1) : cfg_time_quantum_i;
      end
      if (cmd_i.load_en && load_hit) begin
        remaining_q[PtrW'(slot_index_q)] <= burst_time_q;
      end
      if (cmd_i.step_en && any_busy) begin
        remaining_q[sel] <= fin ? '0 : sel_rem - quantum_q;
        pointer_q        <= (sel == LastSlot) ? '0 : sel + PtrW'(1);
      end
    end
  end

endmodule

[rtl/rrqs_controller.sv]
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler controller
// Request capture, execute sequencing and result valid tracking.
// ----------------------------------------------------------------------------
module rrqs_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rrqs_pkg::dp_sts_t   sts_i,
  output rrqs_pkg::ctrl_cmd_t cmd_o
);
  import rrqs_pkg::*;

  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.capture = (state_q == StIdle) && in_valid_i;
    cmd_o.load_en = (state_q == StExec) && !sts_i.cmd_step;
    cmd_o.step_en = (state_q == StExec) && sts_i.cmd_step && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      // A step that finds the result register free fills it.
      if (cmd_o.step_en) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StExec;
          end
        end
        StExec: begin
          if (!sts_i.cmd_step) begin
            state_q <= StIdle;
          end else if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

[rtl/round_robin_quantum_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler unit
// Top level joining the scheduler controller and datapath to the channels.
// ----------------------------------------------------------------------------
// The block takes requests on req_i. A load request writes one slot's
// remaining time and gives no result. A step request picks the next busy slot
// in circular order from the turn pointer, grants it the quantum or its
// remaining time, whichever is smaller, and returns one result on rsp_o.
// The user must see that the quantum is written on cfg_i only while the block
// is idle; the block itself does not enforce this. Zero is taken as one.
// Each request passes through a capture state that registers it and an
// execute state in which the datapath performs the pick and update. A step's
// result is loaded into the output register, and rsp_o.valid rises, as the step
// leaves the execute state. No new request is accepted until then.
// A finished result waits in the output register while the next request is
// accepted. If that next request is a step and the receiver still stalls,
// the controller holds in its execute state until the result register frees.
// Reset clears all slot times, the turn pointer and any pending result, and
// sets the quantum to one.
// ----------------------------------------------------------------------------
`include "round_robin_quantum_scheduler_unit_defines.svh"

module round_robin_quantum_scheduler_unit #(
  parameter int SLOT_COUNT = rrqs_pkg::SlotCountDefault
) (
  input logic clk_i,
  input logic rst_ni,
  rrqs_cfg_if.sink   cfg_i,
  rrqs_req_if.sink   req_i,
  rrqs_rsp_if.source rsp_o
);
  import rrqs_pkg::*;

  ctrl_cmd_t        ctrl_cmd;
  dp_sts_t          dp_sts;
  logic [TimeW-1:0] quantum;

  // Configuration writes must only be made while idle (not enforced); all are taken.
  assign cfg_i.ready = 1'b1;

  rrqs_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (ctrl_cmd)
  );

  rrqs_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (ctrl_cmd),
    .sts_o              (dp_sts),
    .req_command_i      (req_i.command),
    .req_slot_index_i   (req_i.slot_index),
    .req_burst_time_i   (req_i.burst_time),
    .cfg_we_i           (cfg_i.valid),
    .cfg_time_quantum_i (cfg_i.time_quantum),
    .quantum_o          (quantum),
    .served_slot_o      (rsp_o.served_slot),
    .run_time_o         (rsp_o.run_time),
    .job_finished_o     (rsp_o.job_finished),
    .all_idle_o         (rsp_o.all_idle)
  );

  // A served slot always gets at least one time unit; only an idle turn gets none.
  `RRQS_ASSERT_SAME(a_run_time_idle, rsp_o.valid,
                    (rsp_o.run_time == '0) == rsp_o.all_idle,
                    "run time and idle flag disagree")

  // An idle turn reports slot zero and no finished job.
  `RRQS_ASSERT_SAME(a_idle_fields, rsp_o.valid && rsp_o.all_idle,
                    !rsp_o.job_finished && (rsp_o.served_slot == '0),
                    "idle result carries a served slot")

  // An accepted request occupies the execute cycle, so no request is taken next.
  `RRQS_ASSERT_NEXT(a_one_at_a_time, req_i.valid && req_i.ready, !req_i.ready,
                    "request accepted during execute")

  // A granted run never exceeds the quantum in force.
  `RRQS_ASSERT_SAME(a_run_in_quantum, rsp_o.valid, rsp_o.run_time <= quantum,
                    "run time above quantum")

endmodule
